@@ sv/ugpb_pkg.sv @@
// ----------------------------------------------------------------------------
// ugpb_pkg
// Shared types, constants and codes for the uniform grid particle binning unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ugpb_pkg;

  // Sizing
  localparam int CELL_CAPACITY = 16;
  localparam int GRID_DIM_MAX  = 16;
  localparam int ID_BITS       = 16;

  localparam int NUM_CELLS   = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int NUM_ENTRIES = NUM_CELLS * CELL_CAPACITY;
  localparam int CELL_AW     = $clog2(NUM_CELLS);
  localparam int SLOT_AW     = $clog2(CELL_CAPACITY);
  localparam int ENT_AW      = CELL_AW + SLOT_AW;
  localparam int CNT_W       = $clog2(CELL_CAPACITY + 1);
  localparam int COORD_W     = $clog2(GRID_DIM_MAX);
  localparam int DIM_W       = $clog2(GRID_DIM_MAX + 1);
  localparam int PLANE_W     = $clog2(GRID_DIM_MAX * GRID_DIM_MAX + 1);
  localparam int NCELL_W     = $clog2(NUM_CELLS + 1);
  localparam int ROW_W       = 2 * COORD_W;

  // Register map
  localparam int NUM_REGS = 7;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
  localparam int GRID_W   = 5;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_INV   = 3'd3;
  localparam logic [2:0] REG_GX    = 3'd4;
  localparam logic [2:0] REG_GY    = 3'd5;
  localparam logic [2:0] REG_GZ    = 3'd6;

  // Opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OOB  = 2'd2;

  // Result kinds loaded into the output register
  localparam logic [1:0] K_EMPTY = 2'd0;
  localparam logic [1:0] K_OOB   = 2'd1;
  localparam logic [1:0] K_INS   = 2'd2;
  localparam logic [1:0] K_RD    = 2'd3;

  // Axis select
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Slot value reported when no slot was written
  localparam logic [4:0] NO_SLOT = 5'(CELL_CAPACITY);

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic [31:0]        inv;
    logic [DIM_W-1:0]   gx;
    logic [DIM_W-1:0]   gy;
    logic [DIM_W-1:0]   gz;
    logic [NCELL_W-1:0] used;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       sub;
    logic       mul;
    logic       chk;
    logic [1:0] axis;
    logic       idx_a;
    logic       idx_b;
    logic       rd_path;
    logic       sweep_wr;
    logic       load;
    logic [1:0] kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       oob;
    logic       sweep_last;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/ugpb_cfg.sv @@
// ----------------------------------------------------------------------------
// ugpb_cfg
// APB register file: box corner, reciprocal cell size and grid dimensions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugpb_cfg
  import ugpb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [31:0]        min_x;
  logic [31:0]        min_y;
  logic [31:0]        min_z;
  logic [31:0]        inv;
  logic [GRID_W-1:0]  grid_x;
  logic [GRID_W-1:0]  grid_y;
  logic [GRID_W-1:0]  grid_z;
  logic [DIM_W-1:0]   gx_eff;
  logic [DIM_W-1:0]   gy_eff;
  logic [DIM_W-1:0]   gz_eff;
  logic [PLANE_W-1:0] plane;
  logic [NCELL_W-1:0] used;
  logic               wr_en;
  logic [2:0]         reg_idx;

  // Clamp a grid size register to 1..GRID_DIM_MAX
  function automatic logic [DIM_W-1:0] eff_dim(input logic [GRID_W-1:0] g);
    logic [DIM_W-1:0] r;
    if (g == '0) begin
      r = DIM_W'(1);
    end else if (int'(g) > GRID_DIM_MAX) begin
      r = DIM_W'(GRID_DIM_MAX);
    end else begin
      r = DIM_W'(g);
    end
    return r;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x  <= '0;
      min_y  <= '0;
      min_z  <= '0;
      inv    <= 32'd65536;
      grid_x <= GRID_W'(16);
      grid_y <= GRID_W'(16);
      grid_z <= GRID_W'(16);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_X: min_x  <= pwdata;
        REG_MIN_Y: min_y  <= pwdata;
        REG_MIN_Z: min_z  <= pwdata;
        REG_INV:   inv    <= pwdata;
        REG_GX:    grid_x <= pwdata[GRID_W-1:0];
        REG_GY:    grid_y <= pwdata[GRID_W-1:0];
        REG_GZ:    grid_z <= pwdata[GRID_W-1:0];
        default:   ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MIN_X: prdata = min_x;
      REG_MIN_Y: prdata = min_y;
      REG_MIN_Z: prdata = min_z;
      REG_INV:   prdata = inv;
      REG_GX:    prdata = 32'(grid_x);
      REG_GY:    prdata = 32'(grid_y);
      REG_GZ:    prdata = 32'(grid_z);
      default:   prdata = '0;
    endcase
  end

  assign gx_eff = eff_dim(grid_x);
  assign gy_eff = eff_dim(grid_y);
  assign gz_eff = eff_dim(grid_z);

  // Cells in use, one product per stage
  always_ff @(posedge clk) begin
    plane <= PLANE_W'(gx_eff * gy_eff);
    used  <= NCELL_W'(plane * gz_eff);
  end

  assign cfg.min_x = min_x;
  assign cfg.min_y = min_y;
  assign cfg.min_z = min_z;
  assign cfg.inv   = inv;
  assign cfg.gx    = gx_eff;
  assign cfg.gy    = gy_eff;
  assign cfg.gz    = gz_eff;
  assign cfg.used  = used;

endmodule

`default_nettype wire

@@ sv/ugpb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ugpb_ctrl
// Sequencer: steps the datapath through clear sweep, insert and read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugpb_ctrl
  import ugpb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         cmd,
  input  wire dp_sts_t    sts
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_SUB   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_IDX1  = 4'd6;
  localparam logic [3:0] S_IDX2  = 4'd7;
  localparam logic [3:0] S_ICNT  = 4'd8;
  localparam logic [3:0] S_IFIN  = 4'd9;
  localparam logic [3:0] S_RCNT  = 4'd10;
  localparam logic [3:0] S_RFIN  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] axis;
  logic [1:0] axis_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          axis_next = AX_X;
          unique case (opcode)
            OP_CLEAR:  state_next = S_CLEAR;
            OP_INSERT: state_next = S_SUB;
            OP_READ:   state_next = S_RCNT;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_next = S_DONE;
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (axis == AX_Z) begin
          state_next = S_IDX1;
        end else begin
          axis_next  = 2'(axis + 2'd1);
          state_next = S_SUB;
        end
      end
      S_IDX1: begin
        if (sts.oob) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_a  = 1'b1;
          state_next = S_IDX2;
        end
      end
      S_IDX2: begin
        cmd.idx_b  = 1'b1;
        state_next = S_ICNT;
      end
      S_ICNT: begin
        state_next = S_IFIN;
      end
      S_IFIN: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = K_INS;
          state_next = S_IDLE;
        end
      end
      S_RCNT: begin
        cmd.rd_path = 1'b1;
        state_next  = S_RFIN;
      end
      S_RFIN: begin
        cmd.rd_path = 1'b1;
        if (out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = K_RD;
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = (sts.op == OP_INSERT) ? K_OOB : K_EMPTY;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  // Output word handshake
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      axis      <= AX_X;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/ugpb_dp.sv @@
// ----------------------------------------------------------------------------
// ugpb_dp
// Datapath: cell coordinate arithmetic, count and entry memories, result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugpb_dp
  import ugpb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_sts_t                 sts,
  input  wire cfg_t               cfg,
  input  wire logic [1:0]         opcode,
  input  wire logic [15:0]        particle_id,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [11:0]        read_cell,
  input  wire logic [3:0]         read_slot,
  output logic [1:0]              status,
  output logic [3:0]              cell_x,
  output logic [3:0]              cell_y,
  output logic [3:0]              cell_z,
  output logic [11:0]             cell_index,
  output logic [4:0]              slot,
  output logic [4:0]              count,
  output logic [15:0]             entry_id,
  output logic                    entry_valid
);

  // Latched item
  logic [1:0]         op_r;
  logic [ID_BITS-1:0] pid_r;
  logic signed [31:0] px_r;
  logic signed [31:0] py_r;
  logic signed [31:0] pz_r;
  logic [11:0]        rcell_r;
  logic [3:0]         rslot_r;

  // Coordinate arithmetic
  logic signed [31:0] pos_sel;
  logic signed [31:0] min_sel;
  logic [DIM_W-1:0]   dim_sel;
  logic signed [32:0] diff;
  logic [31:0]        prod_hi;
  logic               neg;
  logic               bad;
  logic               oob;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [COORD_W-1:0] cz;
  logic [ROW_W-1:0]   row;
  logic [CELL_AW-1:0] ci;

  // Memories
  logic [CNT_W-1:0]   cnt_mem [NUM_CELLS];
  logic [ID_BITS-1:0] ent_mem [NUM_ENTRIES];
  logic [CNT_W-1:0]   cnt_rdata;
  logic [ID_BITS-1:0] ent_rdata;
  logic [CELL_AW-1:0] cnt_raddr;
  logic [CELL_AW-1:0] cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic               cnt_we;
  logic [ENT_AW-1:0]  ent_raddr;
  logic [ENT_AW-1:0]  ent_waddr;
  logic               ent_we;
  logic [CELL_AW-1:0] sweep_addr;

  // Result terms
  logic               full;
  logic               in_grid;
  logic               hit;

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= opcode;
      pid_r   <= ID_BITS'(particle_id);
      px_r    <= pos_x;
      py_r    <= pos_y;
      pz_r    <= pos_z;
      rcell_r <= read_cell;
      rslot_r <= read_slot;
    end
  end

  // Axis selection
  always_comb begin
    case (cmd.axis)
      AX_X: begin
        pos_sel = px_r;
        min_sel = cfg.min_x;
        dim_sel = cfg.gx;
      end
      AX_Y: begin
        pos_sel = py_r;
        min_sel = cfg.min_y;
        dim_sel = cfg.gy;
      end
      default: begin
        pos_sel = pz_r;
        min_sel = cfg.min_z;
        dim_sel = cfg.gz;
      end
    endcase
  end

  // A negative offset is out of the box unless the reciprocal is zero
  assign bad = neg ? (cfg.inv != '0) : (prod_hi >= 32'(dim_sel));

  // Subtract, multiply, check: one axis at a time
  always_ff @(posedge clk) begin
    if (cmd.sub) begin
      diff <= 33'(pos_sel) - 33'(min_sel);
    end
    if (cmd.mul) begin
      neg     <= diff[32];
      prod_hi <= 32'((64'(diff[31:0]) * 64'(cfg.inv)) >> 32);
    end
    if (cmd.chk) begin
      case (cmd.axis)
        AX_X:    cx <= neg ? '0 : prod_hi[COORD_W-1:0];
        AX_Y:    cy <= neg ? '0 : prod_hi[COORD_W-1:0];
        default: cz <= neg ? '0 : prod_hi[COORD_W-1:0];
      endcase
    end
    if (cmd.idx_a) begin
      row <= ROW_W'(cz * cfg.gy + ROW_W'(cy));
    end
    if (cmd.idx_b) begin
      ci <= CELL_AW'(row * cfg.gx + CELL_AW'(cx));
    end
  end

  // Out-of-box flag, cleared per word
  always_ff @(posedge clk) begin
    if (rst) begin
      oob <= 1'b0;
    end else if (cmd.latch) begin
      oob <= 1'b0;
    end else if (cmd.chk && bad) begin
      oob <= 1'b1;
    end
  end

  // Clearing sweep address, wraps to zero at the end of a pass
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_addr <= CELL_AW'(sweep_addr + 1'b1);
    end
  end

  assign full    = (cnt_rdata >= CNT_W'(CELL_CAPACITY));
  assign in_grid = (NCELL_W'(rcell_r) < cfg.used);
  assign hit     = in_grid && (CNT_W'(rslot_r) < cnt_rdata);

  // Memory ports
  assign cnt_raddr = cmd.rd_path ? CELL_AW'(rcell_r) : ci;
  assign cnt_we    = cmd.sweep_wr || (cmd.load && (cmd.kind == K_INS) && !full);
  assign cnt_waddr = cmd.sweep_wr ? sweep_addr : ci;
  assign cnt_wdata = cmd.sweep_wr ? '0 : CNT_W'(cnt_rdata + 1'b1);
  assign ent_we    = cmd.load && (cmd.kind == K_INS) && !full;
  assign ent_waddr = {ci, cnt_rdata[SLOT_AW-1:0]};
  assign ent_raddr = {CELL_AW'(rcell_r), SLOT_AW'(rslot_r)};

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= pid_r;
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= ST_OK;
      cell_x      <= '0;
      cell_y      <= '0;
      cell_z      <= '0;
      cell_index  <= '0;
      slot        <= NO_SLOT;
      count       <= '0;
      entry_id    <= '0;
      entry_valid <= 1'b0;
      case (cmd.kind)
        K_OOB: begin
          status <= ST_OOB;
        end
        K_INS: begin
          status     <= full ? ST_FULL : ST_OK;
          cell_x     <= 4'(cx);
          cell_y     <= 4'(cy);
          cell_z     <= 4'(cz);
          cell_index <= 12'(ci);
          slot       <= full ? NO_SLOT : 5'(cnt_rdata);
          count      <= full ? 5'(cnt_rdata) : 5'(cnt_rdata + 1'b1);
        end
        K_RD: begin
          status      <= in_grid ? ST_OK : ST_OOB;
          cell_index  <= rcell_r;
          count       <= in_grid ? 5'(cnt_rdata) : '0;
          entry_id    <= hit ? 16'(ent_rdata) : '0;
          entry_valid <= hit;
        end
        default: ;
      endcase
    end
  end

  assign sts.op         = op_r;
  assign sts.oob        = oob;
  assign sts.sweep_last = (sweep_addr == CELL_AW'(NUM_CELLS - 1));

endmodule

`default_nettype wire

@@ sv/uniform_grid_particle_binning_unit.sv @@
// ----------------------------------------------------------------------------
// uniform_grid_particle_binning_unit
// Bins particles into a uniform 3-D grid of cell lists; clear, insert, read.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   in        in_valid / in_stall   opcode, particle_id, pos_x/y/z,
//                                   read_cell, read_slot
//   out       out_valid / out_stall status, cell_x/y/z, cell_index, slot,
//                                   count, entry_id, entry_valid
//   cfg       APB psel/penable      paddr, pwdata, prdata (pready tied high)
//
// One word at a time. Insert: three axes through one shared subtract /
// 32x32 multiply / compare unit, then two index steps and a count read;
// an out-of-box insert ends after the compares. Read: count and entry
// memory reads. Opcode three: an empty result word. Clear: a sweep of the
// 4096-entry count memory one cell a cycle, plus the result load. After
// reset the same sweep runs with in_stall high; APB writes are taken
// throughout. A finished word waits in the output register, and the next
// input word is taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uniform_grid_particle_binning_unit
  import ugpb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [15:0]        particle_id,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [11:0]        read_cell,
  input  wire logic [3:0]         read_slot,
  // Output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [3:0]              cell_x,
  output logic [3:0]              cell_y,
  output logic [3:0]              cell_z,
  output logic [11:0]             cell_index,
  output logic [4:0]              slot,
  output logic [4:0]              count,
  output logic [15:0]             entry_id,
  output logic                    entry_valid,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Register file
  ugpb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  ugpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath
  ugpb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .opcode      (opcode),
    .particle_id (particle_id),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .read_cell   (read_cell),
    .read_slot   (read_slot),
    .status      (status),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_z      (cell_z),
    .cell_index  (cell_index),
    .slot        (slot),
    .count       (count),
    .entry_id    (entry_id),
    .entry_valid (entry_valid)
  );

endmodule

`default_nettype wire
